### design/pfp_pkg.sv
// pfp_pkg: constants and phase codes for the paddle frame parser
// no dependencies; imported by paddle_frame_parser
package pfp_pkg;

    localparam int PLAYERS       = 3;
    localparam int PAYLOAD_BYTES = 6;
    localparam int MAX_PLAYERS   = 4;
    localparam int STORE_DEPTH   = 2 * PLAYERS;
    localparam int STORE_IDX_W   = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    localparam logic [7:0] PAYLOAD_LEN = 8'(PAYLOAD_BYTES);
    localparam logic [7:0] SYNC_BYTE   = 8'hAA;
    localparam logic [7:0] LEN_ZERO    = 8'h00;
    localparam logic [7:0] HEADER_LEN  = 8'd2;
    localparam logic [7:0] LENGTH_LEN  = 8'd4;

    localparam logic [1:0] PH_HUNT    = 2'd0;
    localparam logic [1:0] PH_LENGTH  = 2'd1;
    localparam logic [1:0] PH_PAYLOAD = 2'd2;

endpackage

### design/paddle_frame_parser.sv
// paddle_frame_parser: frame hunt, length check, payload capture and player update
// depends on pfp_pkg
//
// One received byte per item; a new item can be taken in every cycle unless the
// result is stalled. Each byte waits in an input register, then the parsing
// logic updates the frame state and player registers, which together with the
// done flag form the result register. While a result is stalled, one more byte
// is still taken into the input register. Every byte gives one result;
// o_frame_done marks the byte that closed a frame.
module paddle_frame_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [7:0] o_paddle_pos_0,
    output logic signed [7:0] o_paddle_pos_1,
    output logic signed [7:0] o_paddle_pos_2,
    output logic signed [7:0] o_paddle_pos_3,
    output logic [3:0]        o_button_flags,
    output logic [7:0]        o_header_errors,
    output logic [7:0]        o_size_errors,
    output logic              o_frame_done
);
    import pfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic       r_done, n_done;
    logic [1:0] r_phase, n_phase;
    logic [7:0] r_left, n_left;
    logic       r_bad, n_bad;
    logic [7:0] r_hdr, n_hdr;
    logic [7:0] r_size, n_size;
    logic [7:0] r_pos [PLAYERS];
    logic [7:0] n_pos [PLAYERS];
    logic       r_flags [PLAYERS];
    logic       n_flags [PLAYERS];
    logic [7:0] r_store [STORE_DEPTH];

    logic       w_adv;
    logic [7:0] w_idx;
    logic [7:0] w_expect;
    logic       w_len_bad;
    logic [7:0] w_hunt_left;
    logic       w_store_we;
    logic [7:0] w_view [STORE_DEPTH];
    logic [7:0] w_pos_all [MAX_PLAYERS];
    logic [3:0] w_flags_all;

    // handshake: input register in front, result register behind
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;
    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

    assign w_idx       = PAYLOAD_LEN - r_left;
    assign w_expect    = (r_left == 8'd1) ? PAYLOAD_LEN : LEN_ZERO;
    assign w_len_bad   = r_bad || (r_in_byte != w_expect);
    assign w_hunt_left = (r_left == 8'd0 || r_left > HEADER_LEN) ? HEADER_LEN : r_left;
    assign w_store_we  = (r_phase == PH_PAYLOAD) && (w_idx < 8'(STORE_DEPTH));

    // payload bytes as seen at frame end, including the byte in flight
    always_comb begin
        for (int k = 0; k < STORE_DEPTH; k++) begin
            if (k >= PAYLOAD_BYTES) begin
                w_view[k] = 8'h00;
            end else if (w_idx == 8'(k)) begin
                w_view[k] = r_in_byte;
            end else begin
                w_view[k] = r_store[k];
            end
        end
    end

    always_comb begin
        n_phase = r_phase;
        n_left  = r_left;
        n_bad   = r_bad;
        n_hdr   = r_hdr;
        n_size  = r_size;
        n_done  = 1'b0;
        for (int n = 0; n < PLAYERS; n++) begin
            n_pos[n]   = r_pos[n];
            n_flags[n] = r_flags[n];
        end
        unique case (r_phase)
            PH_LENGTH: begin
                n_left = r_left - 8'd1;
                n_bad  = w_len_bad;
                if (r_left == 8'd1) begin
                    n_bad = 1'b0;
                    if (w_len_bad) begin
                        n_size  = r_size + 8'd1;
                        n_phase = PH_HUNT;
                        n_left  = HEADER_LEN;
                    end else begin
                        n_phase = PH_PAYLOAD;
                        n_left  = PAYLOAD_LEN;
                    end
                end
            end
            PH_PAYLOAD: begin
                n_left = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    for (int n = 0; n < PLAYERS; n++) begin
                        n_pos[n] = r_pos[n] + w_view[2 * n];
                        if (w_view[2 * n + 1] != 8'h00) begin
                            n_flags[n] = 1'b1;
                        end
                    end
                    n_done  = 1'b1;
                    n_phase = PH_HUNT;
                    n_left  = HEADER_LEN;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (r_in_byte != SYNC_BYTE) begin
                    n_left = HEADER_LEN;
                    n_hdr  = r_hdr + 8'd1;
                end else if (w_hunt_left == 8'd1) begin
                    n_phase = PH_LENGTH;
                    n_left  = LENGTH_LEN;
                    n_bad   = 1'b0;
                end else begin
                    n_left = w_hunt_left - 8'd1;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_left  <= HEADER_LEN;
            r_bad   <= 1'b0;
            r_hdr   <= 8'd0;
            r_size  <= 8'd0;
            r_done  <= 1'b0;
            for (int n = 0; n < PLAYERS; n++) begin
                r_pos[n]   <= 8'd0;
                r_flags[n] <= 1'b0;
            end
        end else if (w_adv) begin
            r_phase <= n_phase;
            r_left  <= n_left;
            r_bad   <= n_bad;
            r_hdr   <= n_hdr;
            r_size  <= n_size;
            r_done  <= n_done;
            for (int n = 0; n < PLAYERS; n++) begin
                r_pos[n]   <= n_pos[n];
                r_flags[n] <= n_flags[n];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_store_we) begin
            r_store[w_idx[STORE_IDX_W-1:0]] <= r_in_byte;
        end
    end

    for (genvar g = 0; g < MAX_PLAYERS; g++) begin : g_player
        if (g < PLAYERS) begin : g_built
            assign w_pos_all[g]   = r_pos[g];
            assign w_flags_all[g] = r_flags[g];
        end else begin : g_absent
            assign w_pos_all[g]   = 8'd0;
            assign w_flags_all[g] = 1'b0;
        end
    end

    assign o_paddle_pos_0  = $signed(w_pos_all[0]);
    assign o_paddle_pos_1  = $signed(w_pos_all[1]);
    assign o_paddle_pos_2  = $signed(w_pos_all[2]);
    assign o_paddle_pos_3  = $signed(w_pos_all[3]);
    assign o_button_flags  = w_flags_all;
    assign o_header_errors = r_hdr;
    assign o_size_errors   = r_size;
    assign o_frame_done    = r_done;

    a_payload_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_left != 8'd0 && r_left <= PAYLOAD_LEN)
        else $error("payload byte count out of range");

    a_length_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_LENGTH |-> r_left != 8'd0 && r_left <= LENGTH_LEN)
        else $error("length byte count out of range");

    a_done_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> r_phase == PH_HUNT && r_left == HEADER_LEN)
        else $error("frame end did not return to header hunt");

    a_hdr_only_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !$past(w_adv) |-> $stable(r_hdr) && $stable(r_size))
        else $error("error count changed without an item");

    a_out_after_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(w_adv))
        else $error("result raised without an item");

endmodule
